FILE: sv/hrc_pkg.sv
`timescale 1ns / 1ps

package hrc_pkg;

   // Commands of the input channel
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_SAMPLE  = 3'd1;
   localparam logic [2:0] CMD_SERIAL  = 3'd2;
   localparam logic [2:0] CMD_BUTTON  = 3'd3;
   localparam logic [2:0] CMD_ENTER   = 3'd4;
   localparam logic [2:0] CMD_LEAVE   = 3'd5;
   localparam logic [2:0] CMD_REFRESH = 3'd6;

   // Buttons
   localparam logic [2:0] BTN_MODE   = 3'd0;
   localparam logic [2:0] BTN_UP     = 3'd1;
   localparam logic [2:0] BTN_DOWN   = 3'd2;
   localparam logic [2:0] BTN_ARM    = 3'd3;
   localparam logic [2:0] BTN_KLIGHT = 3'd4;
   localparam logic [2:0] BTN_KFAN   = 3'd5;
   localparam logic [2:0] BTN_BATH   = 3'd6;

   // Serial command characters
   localparam logic [7:0] SER_MODE      = 8'h73; // s
   localparam logic [7:0] SER_UP        = 8'h74; // t
   localparam logic [7:0] SER_DOWN      = 8'h67; // g
   localparam logic [7:0] SER_LLIGHT_ON = 8'h31; // 1
   localparam logic [7:0] SER_LLIGHT_OFF= 8'h32; // 2
   localparam logic [7:0] SER_LFAN_ON   = 8'h33; // 3
   localparam logic [7:0] SER_LFAN_OFF  = 8'h34; // 4
   localparam logic [7:0] SER_ARM       = 8'h35; // 5
   localparam logic [7:0] SER_DISARM    = 8'h36; // 6
   localparam logic [7:0] SER_KLIGHT_ON = 8'h37; // 7
   localparam logic [7:0] SER_KLIGHT_OFF= 8'h38; // 8
   localparam logic [7:0] SER_KFAN_ON   = 8'h39; // 9
   localparam logic [7:0] SER_KFAN_OFF  = 8'h30; // 0
   localparam logic [7:0] SER_BATH_ON   = 8'h61; // a
   localparam logic [7:0] SER_BATH_OFF  = 8'h62; // b

   // Enable flag masks
   localparam logic [4:0] EN_LLIGHT = 5'h01;
   localparam logic [4:0] EN_LFAN   = 5'h02;
   localparam logic [4:0] EN_KLIGHT = 5'h04;
   localparam logic [4:0] EN_KFAN   = 5'h08;
   localparam logic [4:0] EN_BATH   = 5'h10;

   // Modes
   localparam logic [1:0] MODE_AUTO    = 2'd0;
   localparam logic [1:0] MODE_MANUAL  = 2'd1;
   localparam logic [1:0] MODE_SET_ON  = 2'd2;
   localparam logic [1:0] MODE_SET_OFF = 2'd3;

   // Reset values
   localparam logic [15:0] HOLD_TICKS_RESET = 16'd2300;
   localparam logic [7:0]  ON_LEVEL_RESET   = 8'd22;
   localparam logic [7:0]  OFF_LEVEL_RESET  = 8'd18;
   localparam logic [4:0]  ENABLE_RESET     = EN_LLIGHT | EN_LFAN | EN_KLIGHT | EN_BATH;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_TICK,
      OP_SAMPLE,
      OP_NEXT_MODE,
      OP_LEVEL_UP,
      OP_LEVEL_DOWN,
      OP_BTN_UP,
      OP_BTN_DOWN,
      OP_FLAG_SET,
      OP_FLAG_CLR,
      OP_FLAG_TOG,
      OP_ARM,
      OP_DISARM,
      OP_ARM_TOGGLE,
      OP_ENTER,
      OP_LEAVE,
      OP_REFRESH
   } op_kind_type;

   // arg carries the temperature of a refresh, or {bathroom, kitchen, danger}
   // in its low bits for a sensor sample.
   typedef struct packed {
      op_kind_type kind;
      logic [4:0]  mask;
      logic [7:0]  arg;
   } op_type;

endpackage

FILE: sv/hrc_front.sv
`timescale 1ns / 1ps

module hrc_front import hrc_pkg::*; (
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_serial_byte,
   input  logic [2:0] req_button,
   input  logic       req_gas_detected,
   input  logic       req_flame_detected,
   input  logic       req_kitchen_present,
   input  logic       req_bathroom_present,
   input  logic [7:0] req_temperature,
   input  logic       q_full,
   output logic       q_push,
   output op_type     q_op
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_op.kind = OP_NOP;
      q_op.mask = '0;
      q_op.arg  = '0;
      unique case (req_command)
         CMD_TICK: q_op.kind = OP_TICK;
         CMD_SAMPLE: begin
            q_op.kind = OP_SAMPLE;
            q_op.arg  = {5'd0, req_bathroom_present, req_kitchen_present,
                         req_gas_detected | req_flame_detected};
         end
         CMD_SERIAL: begin
            unique case (req_serial_byte)
               SER_MODE:       q_op.kind = OP_NEXT_MODE;
               SER_UP:         q_op.kind = OP_LEVEL_UP;
               SER_DOWN:       q_op.kind = OP_LEVEL_DOWN;
               SER_LLIGHT_ON:  begin q_op.kind = OP_FLAG_SET; q_op.mask = EN_LLIGHT; end
               SER_LLIGHT_OFF: begin q_op.kind = OP_FLAG_CLR; q_op.mask = EN_LLIGHT; end
               SER_LFAN_ON:    begin q_op.kind = OP_FLAG_SET; q_op.mask = EN_LFAN;   end
               SER_LFAN_OFF:   begin q_op.kind = OP_FLAG_CLR; q_op.mask = EN_LFAN;   end
               SER_ARM:        q_op.kind = OP_ARM;
               SER_DISARM:     q_op.kind = OP_DISARM;
               SER_KLIGHT_ON:  begin q_op.kind = OP_FLAG_SET; q_op.mask = EN_KLIGHT; end
               SER_KLIGHT_OFF: begin q_op.kind = OP_FLAG_CLR; q_op.mask = EN_KLIGHT; end
               SER_KFAN_ON:    begin q_op.kind = OP_FLAG_SET; q_op.mask = EN_KFAN;   end
               SER_KFAN_OFF:   begin q_op.kind = OP_FLAG_CLR; q_op.mask = EN_KFAN;   end
               SER_BATH_ON:    begin q_op.kind = OP_FLAG_SET; q_op.mask = EN_BATH;   end
               SER_BATH_OFF:   begin q_op.kind = OP_FLAG_CLR; q_op.mask = EN_BATH;   end
               default:        q_op.kind = OP_NOP;
            endcase
         end
         CMD_BUTTON: begin
            unique case (req_button)
               BTN_MODE:   q_op.kind = OP_NEXT_MODE;
               BTN_UP:     q_op.kind = OP_BTN_UP;
               BTN_DOWN:   q_op.kind = OP_BTN_DOWN;
               BTN_ARM:    q_op.kind = OP_ARM_TOGGLE;
               BTN_KLIGHT: begin q_op.kind = OP_FLAG_TOG; q_op.mask = EN_KLIGHT; end
               BTN_KFAN:   begin q_op.kind = OP_FLAG_TOG; q_op.mask = EN_KFAN;   end
               BTN_BATH:   begin q_op.kind = OP_FLAG_TOG; q_op.mask = EN_BATH;   end
               default:    q_op.kind = OP_NOP;
            endcase
         end
         CMD_ENTER: q_op.kind = OP_ENTER;
         CMD_LEAVE: q_op.kind = OP_LEAVE;
         CMD_REFRESH: begin
            q_op.kind = OP_REFRESH;
            q_op.arg  = req_temperature;
         end
         default: q_op.kind = OP_NOP;
      endcase
   end

endmodule

FILE: sv/hrc_queue.sv
`timescale 1ns / 1ps

module hrc_queue import hrc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   pop_valid,
   output op_type pop_op
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   op_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !pop_valid)) else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

FILE: sv/hrc_back.sv
`timescale 1ns / 1ps

module hrc_back import hrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        q_valid,
   input  op_type      q_op,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_living_light,
   output logic        rsp_living_fan,
   output logic        rsp_kitchen_light,
   output logic        rsp_kitchen_fan,
   output logic        rsp_bathroom_light,
   output logic        rsp_intruder_alarm,
   output logic        rsp_kitchen_alarm,
   output logic [1:0]  rsp_mode,
   output logic [7:0]  rsp_fan_on_level,
   output logic [7:0]  rsp_fan_off_level,
   output logic [7:0]  rsp_occupants
);

   logic [15:0] hold_ticks_ff;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  on_level_ff, on_level_in;
   logic [7:0]  off_level_ff, off_level_in;
   logic [7:0]  people_ff, people_in;
   logic        armed_ff, armed_in;
   logic        alarm_on_ff, alarm_on_in;
   logic        hold_running_ff, hold_running_in;
   logic [15:0] hold_count_ff, hold_count_in;
   logic        fan_hyst_ff, fan_hyst_in;
   logic [4:0]  enable_ff, enable_in;
   logic        danger_ff, danger_in;
   logic [1:0]  presence_ff, presence_in;
   logic [5:0]  loads_ff, loads_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_loads_ff;
   logic        rsp_alarm_ff;
   logic [1:0]  rsp_mode_ff;
   logic [7:0]  rsp_on_ff, rsp_off_ff, rsp_people_ff;

   logic        do_up, do_down;
   logic        up_on_ok, up_off_ok, down_on_ok, down_off_ok;
   logic        setting;
   logic [15:0] tick_count;
   logic        occupied, kin, bin, autom;
   logic        refresh_hyst;
   logic [5:0]  refresh_loads;

   // Execute one queued item per cycle whenever the output slot frees up.
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   assign setting     = (mode_ff == MODE_SET_ON) || (mode_ff == MODE_SET_OFF);
   assign up_on_ok    = (on_level_ff != 8'hFF);
   assign up_off_ok   = ({1'b0, off_level_ff} + 9'd1) < {1'b0, on_level_ff};
   assign down_on_ok  = {1'b0, on_level_ff} > ({1'b0, off_level_ff} + 9'd1);
   assign down_off_ok = (off_level_ff != 8'd0);
   assign tick_count  = hold_count_ff + 16'd1;

   assign occupied = (people_ff != 8'd0);
   assign kin      = presence_ff[0];
   assign bin      = presence_ff[1];
   assign autom    = (mode_ff == MODE_AUTO);

   always_comb begin
      refresh_hyst = fan_hyst_ff;
      if (occupied && enable_ff[1]) begin
         if (on_level_ff <= q_op.arg) refresh_hyst = 1'b1;
         if (off_level_ff >= q_op.arg) refresh_hyst = 1'b0;
      end
      refresh_loads[0] = occupied && enable_ff[0];
      refresh_loads[1] = occupied && enable_ff[1] && refresh_hyst;
      refresh_loads[2] = enable_ff[2] && (!autom || kin);
      refresh_loads[3] = enable_ff[3] || danger_ff;
      refresh_loads[4] = enable_ff[4] && (!autom || bin);
      refresh_loads[5] = (kin && armed_ff) || danger_ff;
   end

   always_comb begin
      mode_in         = mode_ff;
      on_level_in     = on_level_ff;
      off_level_in    = off_level_ff;
      people_in       = people_ff;
      armed_in        = armed_ff;
      alarm_on_in     = alarm_on_ff;
      hold_running_in = hold_running_ff;
      hold_count_in   = hold_count_ff;
      fan_hyst_in     = fan_hyst_ff;
      enable_in       = enable_ff;
      danger_in       = danger_ff;
      presence_in     = presence_ff;
      loads_in        = loads_ff;
      do_up           = 1'b0;
      do_down         = 1'b0;

      unique case (q_op.kind) inside
         OP_NOP: ;
         OP_TICK: begin
            if (hold_running_ff) begin
               hold_count_in = tick_count;
               if (tick_count == hold_ticks_ff) begin
                  hold_count_in = '0;
                  if (armed_ff && alarm_on_ff) begin
                     alarm_on_in     = 1'b0;
                     hold_running_in = 1'b0;
                  end
               end
            end
         end
         OP_SAMPLE: begin
            danger_in   = q_op.arg[0];
            presence_in = q_op.arg[2:1];
         end
         OP_NEXT_MODE:  mode_in = mode_ff + 2'd1;
         OP_LEVEL_UP:   do_up = 1'b1;
         OP_LEVEL_DOWN: do_down = 1'b1;
         OP_BTN_UP: begin
            if (setting) do_up = 1'b1;
            else enable_in = enable_ff ^ EN_LLIGHT;
         end
         OP_BTN_DOWN: begin
            if (setting) do_down = 1'b1;
            else enable_in = enable_ff ^ EN_LFAN;
         end
         OP_FLAG_SET: enable_in = enable_ff | q_op.mask;
         OP_FLAG_CLR: enable_in = enable_ff & ~q_op.mask;
         OP_FLAG_TOG: enable_in = enable_ff ^ q_op.mask;
         OP_ARM:      armed_in = 1'b1;
         OP_DISARM: begin
            armed_in    = 1'b0;
            alarm_on_in = 1'b0;
         end
         OP_ARM_TOGGLE: begin
            armed_in = !armed_ff;
            if (armed_ff) alarm_on_in = 1'b0;
         end
         OP_ENTER, OP_LEAVE: begin
            if (armed_ff) begin
               alarm_on_in     = 1'b1;
               hold_count_in   = '0;
               hold_running_in = 1'b1;
            end
            if (q_op.kind == OP_ENTER) begin
               if (people_ff != 8'hFF) people_in = people_ff + 8'd1;
            end else begin
               if (people_ff != 8'd0) people_in = people_ff - 8'd1;
            end
         end
         OP_REFRESH: begin
            // Setting modes keep the loads as they were.
            if (!setting) begin
               fan_hyst_in = refresh_hyst;
               loads_in    = refresh_loads;
            end
         end
         default: ;
      endcase

      if (do_up) begin
         if (mode_ff == MODE_SET_ON && up_on_ok) on_level_in = on_level_ff + 8'd1;
         else if (mode_ff == MODE_SET_OFF && up_off_ok) off_level_in = off_level_ff + 8'd1;
      end
      if (do_down) begin
         if (mode_ff == MODE_SET_ON && down_on_ok) on_level_in = on_level_ff - 8'd1;
         else if (mode_ff == MODE_SET_OFF && down_off_ok) off_level_in = off_level_ff - 8'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff   <= HOLD_TICKS_RESET;
         mode_ff         <= MODE_AUTO;
         on_level_ff     <= ON_LEVEL_RESET;
         off_level_ff    <= OFF_LEVEL_RESET;
         people_ff       <= '0;
         armed_ff        <= 1'b0;
         alarm_on_ff     <= 1'b0;
         hold_running_ff <= 1'b0;
         hold_count_ff   <= '0;
         fan_hyst_ff     <= 1'b1;
         enable_ff       <= ENABLE_RESET;
         danger_ff       <= 1'b0;
         presence_ff     <= '0;
         loads_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) hold_ticks_ff <= csr_wr_data;
         if (q_pop) begin
            mode_ff         <= mode_in;
            on_level_ff     <= on_level_in;
            off_level_ff    <= off_level_in;
            people_ff       <= people_in;
            armed_ff        <= armed_in;
            alarm_on_ff     <= alarm_on_in;
            hold_running_ff <= hold_running_in;
            hold_count_ff   <= hold_count_in;
            fan_hyst_ff     <= fan_hyst_in;
            enable_ff       <= enable_in;
            danger_ff       <= danger_in;
            presence_ff     <= presence_in;
            loads_ff        <= loads_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the state after this item into the output slot.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_loads_ff  <= loads_in;
         rsp_alarm_ff  <= alarm_on_in;
         rsp_mode_ff   <= mode_in;
         rsp_on_ff     <= on_level_in;
         rsp_off_ff    <= off_level_in;
         rsp_people_ff <= people_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_living_light   = rsp_loads_ff[0];
   assign rsp_living_fan     = rsp_loads_ff[1];
   assign rsp_kitchen_light  = rsp_loads_ff[2];
   assign rsp_kitchen_fan    = rsp_loads_ff[3];
   assign rsp_bathroom_light = rsp_loads_ff[4];
   assign rsp_kitchen_alarm  = rsp_loads_ff[5];
   assign rsp_intruder_alarm = rsp_alarm_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_fan_on_level   = rsp_on_ff;
   assign rsp_fan_off_level  = rsp_off_ff;
   assign rsp_occupants      = rsp_people_ff;

   a_levels_apart: assert property (@(posedge clock) disable iff (reset)
      on_level_ff > off_level_ff) else $error("fan thresholds collapsed");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> ($stable(mode_ff) && $stable(people_ff) && $stable(loads_ff)))
      else $error("state changed without an item");

   a_slot_fills: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff) else $error("executed item not presented");

   a_alarm_needs_timer: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_op.kind == OP_ENTER && armed_ff) |=> (alarm_on_ff && hold_running_ff))
      else $error("armed entry did not start the alarm");

endmodule

FILE: sv/home_room_controller.sv
`timescale 1ns / 1ps

// Event controller for the loads of a small home.
// req_*: one event per item (tick, sensor sample, serial byte, button, enter,
//   leave, refresh with temperature), valid/ready handshake.
// rsp_*: exactly one item per event carrying every load drive, the intruder
//   and kitchen alarms, the mode, both fan thresholds and the occupant count
//   as they stand after that event.
// csr_wr_en/csr_wr_data: write the alarm hold time in ticks; write only while
//   no event is in flight.
// Path: an accepted event is registered in the decode queue, then executes
//   straight into the registered response slot.
// Throughput: one event per cycle while rsp_ready is high, set by the single
//   execute step of the back end, which updates all state at once.
// Stalls: the response slot holds while rsp_ready is low; up to two more
//   events wait in the queue, then req_ready drops.
// Reset: mode automatic, thresholds 22/18, nobody inside, disarmed, loads off,
//   hold time 2300 ticks, queue and response slot empty.

module home_room_controller import hrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_serial_byte,
   input  logic [2:0]  req_button,
   input  logic        req_gas_detected,
   input  logic        req_flame_detected,
   input  logic        req_kitchen_present,
   input  logic        req_bathroom_present,
   input  logic [7:0]  req_temperature,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_living_light,
   output logic        rsp_living_fan,
   output logic        rsp_kitchen_light,
   output logic        rsp_kitchen_fan,
   output logic        rsp_bathroom_light,
   output logic        rsp_intruder_alarm,
   output logic        rsp_kitchen_alarm,
   output logic [1:0]  rsp_mode,
   output logic [7:0]  rsp_fan_on_level,
   output logic [7:0]  rsp_fan_off_level,
   output logic [7:0]  rsp_occupants,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic   q_full, q_push, q_valid, q_pop;
   op_type push_op, pop_op;

   hrc_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_serial_byte      (req_serial_byte),
      .req_button           (req_button),
      .req_gas_detected     (req_gas_detected),
      .req_flame_detected   (req_flame_detected),
      .req_kitchen_present  (req_kitchen_present),
      .req_bathroom_present (req_bathroom_present),
      .req_temperature      (req_temperature),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_op                 (push_op)
   );

   hrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_op    (pop_op)
   );

   hrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_valid            (q_valid),
      .q_op               (pop_op),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_living_light   (rsp_living_light),
      .rsp_living_fan     (rsp_living_fan),
      .rsp_kitchen_light  (rsp_kitchen_light),
      .rsp_kitchen_fan    (rsp_kitchen_fan),
      .rsp_bathroom_light (rsp_bathroom_light),
      .rsp_intruder_alarm (rsp_intruder_alarm),
      .rsp_kitchen_alarm  (rsp_kitchen_alarm),
      .rsp_mode           (rsp_mode),
      .rsp_fan_on_level   (rsp_fan_on_level),
      .rsp_fan_off_level  (rsp_fan_off_level),
      .rsp_occupants      (rsp_occupants)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import hrc_pkg::*; ();

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam logic [2:0] BTN_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] serial;
      logic [2:0] btn;
      logic       gas;
      logic       flame;
      logic       kit;
      logic       bath;
      logic [7:0] temp;
   } home_event_type;

   typedef struct packed {
      logic       living_light;
      logic       living_fan;
      logic       kitchen_light;
      logic       kitchen_fan;
      logic       bathroom_light;
      logic       intruder_alarm;
      logic       kitchen_alarm;
      logic [1:0] mode;
      logic [7:0] on_level;
      logic [7:0] off_level;
      logic [7:0] occupants;
   } home_status_type;

   typedef struct packed {
      home_event_type  ev;
      logic            typed;
      home_status_type status;
   } script_row_type;

   typedef enum int {
      TRAFFIC_MIXED,
      TRAFFIC_ARRIVALS,
      TRAFFIC_DEPARTURES,
      TRAFFIC_LEVELS
   } traffic_type;

   localparam home_status_type STATUS_AT_RESET =
      {7'b0, MODE_AUTO, ON_LEVEL_RESET, OFF_LEVEL_RESET, 8'd0};
   localparam home_status_type STATUS_PREDICTED = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = CMD_TICK;
   logic [7:0]  req_serial_byte = 8'd0;
   logic [2:0]  req_button = BTN_MODE;
   logic        req_gas_detected = 1'b0;
   logic        req_flame_detected = 1'b0;
   logic        req_kitchen_present = 1'b0;
   logic        req_bathroom_present = 1'b0;
   logic [7:0]  req_temperature = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_living_light;
   logic        rsp_living_fan;
   logic        rsp_kitchen_light;
   logic        rsp_kitchen_fan;
   logic        rsp_bathroom_light;
   logic        rsp_intruder_alarm;
   logic        rsp_kitchen_alarm;
   logic [1:0]  rsp_mode;
   logic [7:0]  rsp_fan_on_level;
   logic [7:0]  rsp_fan_off_level;
   logic [7:0]  rsp_occupants;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   // controller state as the testbench tracks it
   logic [15:0] hold_ticks = HOLD_TICKS_RESET;
   logic [1:0]  mode_q = MODE_AUTO;
   logic [7:0]  on_lv = ON_LEVEL_RESET;
   logic [7:0]  off_lv = OFF_LEVEL_RESET;
   logic [7:0]  crowd = 8'd0;
   logic        armed_q = 1'b0;
   logic        siren_q = 1'b0;
   logic        hold_run = 1'b0;
   logic [15:0] hold_cnt = 16'd0;
   logic        hyst_q = 1'b1;
   logic [4:0]  en_q = ENABLE_RESET;
   logic        danger_q = 1'b0;
   logic        kit_in = 1'b0;
   logic        bath_in = 1'b0;
   logic        ll_q = 1'b0, lf_q = 1'b0, kl_q = 1'b0, kf_q = 1'b0, bl_q = 1'b0;
   logic        ka_q = 1'b0;

   home_status_type status_due[$];
   script_row_type  script[25];
   logic [1:0]      tune_mode = MODE_SET_ON;
   int              stall_pct = 10;
   int              stall_left = 0;
   int              fail_count = 0;

   home_room_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_serial_byte      (req_serial_byte),
      .req_button           (req_button),
      .req_gas_detected     (req_gas_detected),
      .req_flame_detected   (req_flame_detected),
      .req_kitchen_present  (req_kitchen_present),
      .req_bathroom_present (req_bathroom_present),
      .req_temperature      (req_temperature),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_living_light     (rsp_living_light),
      .rsp_living_fan       (rsp_living_fan),
      .rsp_kitchen_light    (rsp_kitchen_light),
      .rsp_kitchen_fan      (rsp_kitchen_fan),
      .rsp_bathroom_light   (rsp_bathroom_light),
      .rsp_intruder_alarm   (rsp_intruder_alarm),
      .rsp_kitchen_alarm    (rsp_kitchen_alarm),
      .rsp_mode             (rsp_mode),
      .rsp_fan_on_level     (rsp_fan_on_level),
      .rsp_fan_off_level    (rsp_fan_off_level),
      .rsp_occupants        (rsp_occupants),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic home_event_type ev(input logic [2:0] cmd, input logic [7:0] serial,
                                         input logic [2:0] btn, input logic [3:0] sensors,
                                         input logic [7:0] temp);
      return {cmd, serial, btn, sensors, temp};
   endfunction

   function automatic string describe(input home_status_type s);
      return {$sformatf("ll=%0b lf=%0b kl=%0b kf=%0b bl=%0b ia=%0b ka=%0b",
                        s.living_light, s.living_fan, s.kitchen_light, s.kitchen_fan,
                        s.bathroom_light, s.intruder_alarm, s.kitchen_alarm),
              $sformatf(" mode=%0d on=%0d off=%0d occ=%0d",
                        s.mode, s.on_level, s.off_level, s.occupants)};
   endfunction

   // Move the threshold that the current setting mode selects; hold it at its limits.
   task automatic step_level(input logic up);
      if (mode_q == MODE_SET_ON) begin
         if (up) begin
            if (on_lv != 8'hFF) on_lv = on_lv + 8'd1;
         end else if ({1'b0, on_lv} > {1'b0, off_lv} + 9'd1) begin
            on_lv = on_lv - 8'd1;
         end
      end else if (mode_q == MODE_SET_OFF) begin
         if (up) begin
            if ({1'b0, off_lv} + 9'd1 < {1'b0, on_lv}) off_lv = off_lv + 8'd1;
         end else if (off_lv != 8'd0) begin
            off_lv = off_lv - 8'd1;
         end
      end
   endtask

   task automatic raise_siren();
      if (armed_q) begin
         siren_q = 1'b1;
         hold_cnt = 16'd0;
         hold_run = 1'b1;
      end
   endtask

   task automatic home_apply(input home_event_type e, output home_status_type s);
      logic setting;
      setting = (mode_q == MODE_SET_ON) || (mode_q == MODE_SET_OFF);
      case (e.cmd)
         CMD_TICK: begin
            if (hold_run) begin
               hold_cnt = hold_cnt + 16'd1;
               if (hold_cnt == hold_ticks) begin
                  hold_cnt = 16'd0;
                  if (armed_q && siren_q) begin
                     siren_q = 1'b0;
                     hold_run = 1'b0;
                  end
               end
            end
         end
         CMD_SAMPLE: begin
            danger_q = e.gas | e.flame;
            kit_in = e.kit;
            bath_in = e.bath;
         end
         CMD_SERIAL: begin
            case (e.serial)
               SER_MODE:       mode_q = mode_q + 2'd1;
               SER_UP:         step_level(1'b1);
               SER_DOWN:       step_level(1'b0);
               SER_LLIGHT_ON:  en_q = en_q | EN_LLIGHT;
               SER_LLIGHT_OFF: en_q = en_q & ~EN_LLIGHT;
               SER_LFAN_ON:    en_q = en_q | EN_LFAN;
               SER_LFAN_OFF:   en_q = en_q & ~EN_LFAN;
               SER_ARM:        armed_q = 1'b1;
               SER_DISARM: begin
                  armed_q = 1'b0;
                  siren_q = 1'b0;
               end
               SER_KLIGHT_ON:  en_q = en_q | EN_KLIGHT;
               SER_KLIGHT_OFF: en_q = en_q & ~EN_KLIGHT;
               SER_KFAN_ON:    en_q = en_q | EN_KFAN;
               SER_KFAN_OFF:   en_q = en_q & ~EN_KFAN;
               SER_BATH_ON:    en_q = en_q | EN_BATH;
               SER_BATH_OFF:   en_q = en_q & ~EN_BATH;
               default: ;
            endcase
         end
         CMD_BUTTON: begin
            case (e.btn)
               BTN_MODE: mode_q = mode_q + 2'd1;
               BTN_UP: begin
                  if (setting) step_level(1'b1);
                  else en_q = en_q ^ EN_LLIGHT;
               end
               BTN_DOWN: begin
                  if (setting) step_level(1'b0);
                  else en_q = en_q ^ EN_LFAN;
               end
               BTN_ARM: begin
                  armed_q = !armed_q;
                  if (!armed_q) siren_q = 1'b0;
               end
               BTN_KLIGHT: en_q = en_q ^ EN_KLIGHT;
               BTN_KFAN:   en_q = en_q ^ EN_KFAN;
               BTN_BATH:   en_q = en_q ^ EN_BATH;
               default: ;
            endcase
         end
         CMD_ENTER: begin
            raise_siren();
            if (crowd != 8'hFF) crowd = crowd + 8'd1;
         end
         CMD_LEAVE: begin
            raise_siren();
            crowd = (crowd <= 8'd1) ? 8'd0 : crowd - 8'd1;
         end
         CMD_REFRESH: begin
            // setting modes freeze the loads
            if (!setting) begin
               ll_q = (crowd != 8'd0) && ((en_q & EN_LLIGHT) != 0);
               lf_q = 1'b0;
               if ((crowd != 8'd0) && ((en_q & EN_LFAN) != 0)) begin
                  if (on_lv <= e.temp) hyst_q = 1'b1;
                  if (off_lv >= e.temp) hyst_q = 1'b0;
                  lf_q = hyst_q;
               end
               kl_q = ((en_q & EN_KLIGHT) != 0) && (mode_q != MODE_AUTO || kit_in);
               kf_q = ((en_q & EN_KFAN) != 0) || danger_q;
               bl_q = ((en_q & EN_BATH) != 0) && (mode_q != MODE_AUTO || bath_in);
               ka_q = (kit_in && armed_q) || danger_q;
            end
         end
         default: ;
      endcase
      s = {ll_q, lf_q, kl_q, kf_q, bl_q, siren_q, ka_q, mode_q, on_lv, off_lv, crowd};
   endtask

   function automatic home_event_type pick_event(input traffic_type kind, input int up_pct);
      home_event_type e;
      logic [31:0]    raw;
      int             roll;
      logic [7:0]     lo_t, hi_t;
      raw = $urandom;
      e = raw[25:0];
      roll = $urandom_range(0, 99);
      if (kind == TRAFFIC_ARRIVALS && roll < 85) begin
         e.cmd = CMD_ENTER;
         return e;
      end
      if (kind == TRAFFIC_DEPARTURES && roll < 90) begin
         e.cmd = CMD_LEAVE;
         return e;
      end
      if (kind == TRAFFIC_LEVELS && roll < 92) begin
         if (mode_q != tune_mode) begin
            e.cmd = $urandom_range(0, 1) ? CMD_BUTTON : CMD_SERIAL;
            e.btn = BTN_MODE;
            e.serial = SER_MODE;
         end else if ($urandom_range(0, 99) < up_pct) begin
            e.cmd = $urandom_range(0, 1) ? CMD_BUTTON : CMD_SERIAL;
            e.btn = BTN_UP;
            e.serial = SER_UP;
         end else begin
            e.cmd = $urandom_range(0, 1) ? CMD_BUTTON : CMD_SERIAL;
            e.btn = BTN_DOWN;
            e.serial = SER_DOWN;
         end
         return e;
      end
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
         e.cmd = CMD_TICK;
      end else if (roll < 24) begin
         e.cmd = CMD_SAMPLE;
      end else if (roll < 44) begin
         e.cmd = CMD_SERIAL;
         // mostly known characters, the rest arbitrary bytes
         if ($urandom_range(0, 99) < 80) begin
            case ($urandom_range(0, 14))
               0:  e.serial = SER_MODE;
               1:  e.serial = SER_UP;
               2:  e.serial = SER_DOWN;
               3:  e.serial = SER_LLIGHT_ON;
               4:  e.serial = SER_LLIGHT_OFF;
               5:  e.serial = SER_LFAN_ON;
               6:  e.serial = SER_LFAN_OFF;
               7:  e.serial = SER_ARM;
               8:  e.serial = SER_DISARM;
               9:  e.serial = SER_KLIGHT_ON;
               10: e.serial = SER_KLIGHT_OFF;
               11: e.serial = SER_KFAN_ON;
               12: e.serial = SER_KFAN_OFF;
               13: e.serial = SER_BATH_ON;
               default: e.serial = SER_BATH_OFF;
            endcase
         end
      end else if (roll < 62) begin
         e.cmd = CMD_BUTTON;
      end else if (roll < 70) begin
         e.cmd = CMD_ENTER;
      end else if (roll < 78) begin
         e.cmd = CMD_LEAVE;
      end else if (roll < 98) begin
         e.cmd = CMD_REFRESH;
         // keep most temperatures around the hysteresis band
         if ($urandom_range(0, 9) < 7) begin
            lo_t = (off_lv > 8'd3) ? off_lv - 8'd3 : 8'd0;
            hi_t = (on_lv < 8'd252) ? on_lv + 8'd3 : 8'hFF;
            e.temp = 8'($urandom_range(hi_t, lo_t));
         end
      end else begin
         e.cmd = CMD_UNUSED;
      end
      return e;
   endfunction

   task automatic send_item(input home_event_type e, input logic typed,
                            input home_status_type typed_status);
      home_status_type s;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= e.cmd;
      req_serial_byte <= e.serial;
      req_button <= e.btn;
      req_gas_detected <= e.gas;
      req_flame_detected <= e.flame;
      req_kitchen_present <= e.kit;
      req_bathroom_present <= e.bath;
      req_temperature <= e.temp;
      do @(posedge clock); while (!req_ready);
      home_apply(e, s);
      status_due.push_back(typed ? typed_status : s);
   endtask

   // Drop valid and hold until every outstanding status has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
   endtask

   task automatic load_hold_time(input logic [15:0] ticks);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      hold_ticks = ticks;
   endtask

   task automatic run_phase(input traffic_type kind, input int count, input int up_pct,
                            input int gap_pct, input logic flip_tune);
      int gap;
      for (int n = 0; n < count; n++) begin
         if (flip_tune && $urandom_range(0, 19) == 0)
            tune_mode = (tune_mode == MODE_SET_ON) ? MODE_SET_OFF : MODE_SET_ON;
         if (gap_pct != 0 && $urandom_range(0, 249) == 0) begin
            settle();
         end else if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
         end
         send_item(pick_event(kind, up_pct), 1'b0, STATUS_PREDICTED);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      home_status_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_living_light, rsp_living_fan, rsp_kitchen_light, rsp_kitchen_fan,
                rsp_bathroom_light, rsp_intruder_alarm, rsp_kitchen_alarm, rsp_mode,
                rsp_fan_on_level, rsp_fan_off_level, rsp_occupants};
         if (status_due.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: status item with nothing pending: %s", $realtime, describe(got));
            fail_count++;
         end else begin
            want = status_due.pop_front();
            if (got !== want) begin
               if (fail_count < 10)
                  $display("%0t: status mismatch\n  exp %s\n  got %s", $realtime,
                           describe(want), describe(got));
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("home_room_controller verification failed");
      $finish;
   end

   initial begin
      script[0]  = {ev(CMD_TICK, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b1, STATUS_AT_RESET};
      // leave with nobody inside stays at zero
      script[1]  = {ev(CMD_LEAVE, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b1, STATUS_AT_RESET};
      script[2]  = {ev(CMD_UNUSED, 8'hFF, BTN_UNUSED, 4'b1111, 8'hFF), 1'b1, STATUS_AT_RESET};
      script[3]  = {ev(CMD_SERIAL, 8'hFF, BTN_MODE, 4'b0000, 8'd0), 1'b1, STATUS_AT_RESET};
      script[4]  = {ev(CMD_SERIAL, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b1, STATUS_AT_RESET};
      script[5]  = {ev(CMD_BUTTON, 8'h00, BTN_UNUSED, 4'b0000, 8'd0), 1'b1, STATUS_AT_RESET};
      // a sample only latches; loads move at the next refresh
      script[6]  = {ev(CMD_SAMPLE, 8'h00, BTN_MODE, 4'b1011, 8'd0), 1'b1, STATUS_AT_RESET};
      script[7]  = {ev(CMD_REFRESH, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[8]  = {ev(CMD_BUTTON, 8'h00, BTN_ARM, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[9]  = {ev(CMD_ENTER, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[10] = {ev(CMD_TICK, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      // disarm silences the alarm but the hold timer keeps running
      script[11] = {ev(CMD_SERIAL, SER_DISARM, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[12] = {ev(CMD_TICK, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[13] = {ev(CMD_SERIAL, SER_ARM, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[14] = {ev(CMD_ENTER, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      // hold time runs out: alarm drops
      script[15] = {ev(CMD_TICK, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[16] = {ev(CMD_TICK, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[17] = {ev(CMD_REFRESH, 8'h00, BTN_MODE, 4'b0000, 8'hFF), 1'b0, STATUS_PREDICTED};
      script[18] = {ev(CMD_SERIAL, SER_MODE, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[19] = {ev(CMD_BUTTON, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      // refresh while setting the on level keeps the loads
      script[20] = {ev(CMD_REFRESH, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[21] = {ev(CMD_BUTTON, 8'h00, BTN_UP, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[22] = {ev(CMD_SERIAL, SER_DOWN, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[23] = {ev(CMD_BUTTON, 8'h00, BTN_MODE, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};
      script[24] = {ev(CMD_BUTTON, 8'h00, BTN_DOWN, 4'b0000, 8'd0), 1'b0, STATUS_PREDICTED};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_hold_time(16'd2);
      foreach (script[i]) send_item(script[i].ev, script[i].typed, script[i].status);
      settle();

      load_hold_time(16'd3);
      run_phase(TRAFFIC_MIXED, 300, 50, 10, 1'b0);
      settle();

      // fill the house to saturation under back pressure
      load_hold_time(16'd1);
      stall_pct = 25;
      run_phase(TRAFFIC_ARRIVALS, 330, 50, 0, 1'b0);
      settle();

      // walk both thresholds into each other and to zero
      load_hold_time(16'hFFFF);
      stall_pct = 0;
      run_phase(TRAFFIC_LEVELS, 150, 50, 25, 1'b1);

      // push the on level up to its ceiling
      tune_mode = MODE_SET_ON;
      stall_pct = 10;
      run_phase(TRAFFIC_LEVELS, 300, 97, 10, 1'b0);
      settle();

      load_hold_time(16'($urandom_range(2, 6)));
      run_phase(TRAFFIC_DEPARTURES, 250, 50, 10, 1'b0);
      stall_pct = 0;
      run_phase(TRAFFIC_MIXED, 100, 50, 0, 1'b0);
      settle();
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("home_room_controller verification clean");
      else
         $display("home_room_controller verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
sv/hrc_pkg.sv
sv/hrc_front.sv
sv/hrc_queue.sv
sv/hrc_back.sv
sv/home_room_controller.sv
dv/tb.sv
